/* sv/dnsq_pkg.sv */
// Shared types and constants for the DNS question name encoder.
package dnsq_pkg;

	localparam int MAX_LABEL = 32;
	localparam int LBL_AW    = $clog2(MAX_LABEL);
	localparam int CNT_W     = $clog2(MAX_LABEL + 1);

	localparam logic [7:0]  DOT_CHAR  = 8'd46;
	localparam logic [7:0]  END_CHAR  = 8'd0;
	localparam logic [15:0] PTR_MARK  = 16'hC000;
	localparam logic [15:0] CLASS_IN  = 16'h0001;
	localparam logic [15:0] TYPE_A    = 16'h0001;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LEN,
		ST_CHR,
		ST_ROOT,
		ST_PTR_HI,
		ST_PTR_LO,
		ST_TYPE_HI,
		ST_TYPE_LO,
		ST_CLS_HI,
		ST_CLS_LO
	} state_t;

	typedef enum logic [3:0] {
		SRC_LEN,
		SRC_CHR,
		SRC_ZERO,
		SRC_PTR_HI,
		SRC_PTR_LO,
		SRC_TYPE_HI,
		SRC_TYPE_LO,
		SRC_CLS_HI,
		SRC_CLS_LO
	} byte_src_t;

	typedef struct packed {
		logic      take;
		logic      emit;
		byte_src_t src;
		logic      last;
		logic      done;
		logic      lbl_done;
		logic      idx_inc;
	} cmd_t;

	typedef struct packed {
		logic is_ptr;
		logic is_dot;
		logic is_end;
		logic term;
		logic label_empty;
		logic chr_last;
		logic out_free;
	} status_t;

endpackage

/* sv/dnsq_ctrl.sv */
// Sequencer that steps through the bytes of one label, root, pointer, type and class.
module dnsq_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  dnsq_pkg::status_t  st,
	output dnsq_pkg::cmd_t     cmd
);

	dnsq_pkg::state_t state_q;
	dnsq_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dnsq_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		s_tready     = 1'b0;
		cmd.take     = 1'b0;
		cmd.emit     = 1'b0;
		cmd.src      = dnsq_pkg::SRC_ZERO;
		cmd.last     = 1'b0;
		cmd.done     = 1'b0;
		cmd.lbl_done = 1'b0;
		cmd.idx_inc  = 1'b0;
		case (state_q)
			dnsq_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.take = 1'b1;
					if (st.is_ptr) begin
						state_d = dnsq_pkg::ST_PTR_HI;
					end else if (st.is_dot || st.is_end) begin
						state_d = dnsq_pkg::ST_LEN;
					end
				end
			end
			dnsq_pkg::ST_LEN: begin
				cmd.src = dnsq_pkg::SRC_LEN;
				if (st.out_free) begin
					cmd.emit = 1'b1;
					if (st.label_empty) begin
						cmd.lbl_done = 1'b1;
						cmd.last     = !st.term;
						state_d      = st.term ? dnsq_pkg::ST_ROOT : dnsq_pkg::ST_IDLE;
					end else begin
						state_d = dnsq_pkg::ST_CHR;
					end
				end
			end
			dnsq_pkg::ST_CHR: begin
				cmd.src = dnsq_pkg::SRC_CHR;
				if (st.out_free) begin
					cmd.emit    = 1'b1;
					cmd.idx_inc = 1'b1;
					if (st.chr_last) begin
						cmd.lbl_done = 1'b1;
						cmd.last     = !st.term;
						state_d      = st.term ? dnsq_pkg::ST_ROOT : dnsq_pkg::ST_IDLE;
					end
				end
			end
			dnsq_pkg::ST_ROOT: begin
				cmd.src = dnsq_pkg::SRC_ZERO;
				if (st.out_free) begin
					cmd.emit = 1'b1;
					state_d  = dnsq_pkg::ST_TYPE_HI;
				end
			end
			dnsq_pkg::ST_PTR_HI: begin
				cmd.src = dnsq_pkg::SRC_PTR_HI;
				if (st.out_free) begin
					cmd.emit = 1'b1;
					state_d  = dnsq_pkg::ST_PTR_LO;
				end
			end
			dnsq_pkg::ST_PTR_LO: begin
				cmd.src = dnsq_pkg::SRC_PTR_LO;
				if (st.out_free) begin
					cmd.emit = 1'b1;
					state_d  = dnsq_pkg::ST_TYPE_HI;
				end
			end
			dnsq_pkg::ST_TYPE_HI: begin
				cmd.src = dnsq_pkg::SRC_TYPE_HI;
				if (st.out_free) begin
					cmd.emit = 1'b1;
					state_d  = dnsq_pkg::ST_TYPE_LO;
				end
			end
			dnsq_pkg::ST_TYPE_LO: begin
				cmd.src = dnsq_pkg::SRC_TYPE_LO;
				if (st.out_free) begin
					cmd.emit = 1'b1;
					state_d  = dnsq_pkg::ST_CLS_HI;
				end
			end
			dnsq_pkg::ST_CLS_HI: begin
				cmd.src = dnsq_pkg::SRC_CLS_HI;
				if (st.out_free) begin
					cmd.emit = 1'b1;
					state_d  = dnsq_pkg::ST_CLS_LO;
				end
			end
			dnsq_pkg::ST_CLS_LO: begin
				cmd.src = dnsq_pkg::SRC_CLS_LO;
				if (st.out_free) begin
					cmd.emit = 1'b1;
					cmd.last = 1'b1;
					cmd.done = 1'b1;
					state_d  = dnsq_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = dnsq_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

/* sv/dnsq_dp.sv */
// Datapath: label store, label counters, type register and the output word register.
module dnsq_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [15:0]       cfg_wdata,
	input  logic              in_kind,
	input  logic [7:0]        in_ch,
	input  logic [13:0]       in_ptr,
	input  dnsq_pkg::cmd_t    cmd,
	output dnsq_pkg::status_t st,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [7:0]        out_byte,
	output logic              out_last,
	output logic              out_done,
	output logic              out_ovf
);

	logic [7:0]                   label_mem [dnsq_pkg::MAX_LABEL];
	logic [dnsq_pkg::CNT_W-1:0]   count_q;
	logic [dnsq_pkg::CNT_W-1:0]   idx_q;
	logic [dnsq_pkg::CNT_W-1:0]   idx_d;
	logic                         ovf_q;
	logic                         term_q;
	logic [15:0]                  qtype_q;
	logic [15:0]                  ptr_word_q;
	logic [7:0]                   rd_data_q;
	logic                         valid_q;
	logic [7:0]                   byte_q;
	logic                         last_q;
	logic                         done_q;
	logic                         flag_q;
	logic [7:0]                   byte_d;
	logic                         flag_d;
	logic                         is_plain;
	logic                         room;

	assign is_plain = !in_kind && (in_ch != dnsq_pkg::DOT_CHAR) && (in_ch != dnsq_pkg::END_CHAR);
	assign room     = count_q < dnsq_pkg::CNT_W'(dnsq_pkg::MAX_LABEL);

	assign st.is_ptr      = in_kind;
	assign st.is_dot      = !in_kind && (in_ch == dnsq_pkg::DOT_CHAR);
	assign st.is_end      = !in_kind && (in_ch == dnsq_pkg::END_CHAR);
	assign st.term        = term_q;
	assign st.label_empty = (count_q == '0);
	assign st.chr_last    = ((idx_q + dnsq_pkg::CNT_W'(1)) == count_q);
	assign st.out_free    = !valid_q || out_ready;

	// read address follows the next index so the data lines up with the CHR byte
	assign idx_d = cmd.take ? '0 : (cmd.idx_inc ? idx_q + dnsq_pkg::CNT_W'(1) : idx_q);

	always_ff @(posedge clk) begin
		if (cmd.take && is_plain && room) begin
			label_mem[count_q[dnsq_pkg::LBL_AW-1:0]] <= in_ch;
		end
		rd_data_q <= label_mem[idx_d[dnsq_pkg::LBL_AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			idx_q   <= '0;
			ovf_q   <= 1'b0;
			term_q  <= 1'b0;
			qtype_q <= dnsq_pkg::TYPE_A;
			valid_q <= 1'b0;
		end else begin
			idx_q <= idx_d;
			if (cfg_we) begin
				qtype_q <= cfg_wdata;
			end
			if (cmd.take) begin
				term_q <= st.is_end;
				if (in_kind) begin
					count_q <= '0;
					ovf_q   <= 1'b0;
				end else if (is_plain) begin
					if (room) begin
						count_q <= count_q + dnsq_pkg::CNT_W'(1);
					end else begin
						ovf_q <= 1'b1;
					end
				end
			end else if (cmd.lbl_done) begin
				count_q <= '0;
				ovf_q   <= 1'b0;
			end
			if (cmd.emit) begin
				valid_q <= 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		byte_d = 8'd0;
		flag_d = 1'b0;
		case (cmd.src)
			dnsq_pkg::SRC_LEN: begin
				byte_d = 8'(count_q);
				flag_d = ovf_q;
			end
			dnsq_pkg::SRC_CHR: begin
				byte_d = rd_data_q;
				flag_d = ovf_q;
			end
			dnsq_pkg::SRC_ZERO:    byte_d = 8'd0;
			dnsq_pkg::SRC_PTR_HI:  byte_d = ptr_word_q[15:8];
			dnsq_pkg::SRC_PTR_LO:  byte_d = ptr_word_q[7:0];
			dnsq_pkg::SRC_TYPE_HI: byte_d = qtype_q[15:8];
			dnsq_pkg::SRC_TYPE_LO: byte_d = qtype_q[7:0];
			dnsq_pkg::SRC_CLS_HI:  byte_d = dnsq_pkg::CLASS_IN[15:8];
			dnsq_pkg::SRC_CLS_LO:  byte_d = dnsq_pkg::CLASS_IN[7:0];
			default:               byte_d = 8'd0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			ptr_word_q <= dnsq_pkg::PTR_MARK | {2'b00, in_ptr};
		end
		if (cmd.emit) begin
			byte_q <= byte_d;
			last_q <= cmd.last;
			done_q <= cmd.done;
			flag_q <= flag_d;
		end
	end

	assign out_valid = valid_q;
	assign out_byte  = byte_q;
	assign out_last  = last_q;
	assign out_done  = done_q;
	assign out_ovf   = flag_q;

endmodule

/* sv/dns_question_name_encoder_top.sv */
// Top level of the DNS question name encoder: stream ports, sequencer and datapath.
// A name character is stored when taken and yields no word; a dot, terminator or
// pointer is registered in the sequencer state, then its first word in the output
// word register once that is free. Name characters are taken while idle; the input is
// held off while the words of a dot, terminator or pointer go out, and while stalled.
// Reset: sequencer idle, label empty, query_type = 1; label store contents are not reset.
module dns_question_name_encoder_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,    // query_type
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,      // ch[7:0], ptr_offset[21:8], zero pad
	input  logic        s_tuser,      // kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,      // out_byte
	output logic        m_tlast,      // last_of_run
	output logic [1:0]  m_tuser       // question_done[0], label_overflow[1]
);

	dnsq_pkg::cmd_t    cmd;
	dnsq_pkg::status_t st;

	dnsq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.st       (st),
		.cmd      (cmd)
	);

	dnsq_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_kind   (s_tuser),
		.in_ch     (s_tdata[7:0]),
		.in_ptr    (s_tdata[21:8]),
		.cmd       (cmd),
		.st        (st),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_byte  (m_tdata),
		.out_last  (m_tlast),
		.out_done  (m_tuser[0]),
		.out_ovf   (m_tuser[1])
	);

`ifndef SYNTH
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!m_tvalid || m_tready))
		else $error("word loaded while the output word is stalled");

	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[0]) |-> (m_tlast && !m_tuser[1]))
		else $error("question end word without last mark or with overflow flag");

	a_take_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take |-> !cmd.emit)
		else $error("input accepted while a word is being produced");
`endif

endmodule
